/* rtl/iars_pkg.sv */
// ----------------------------------------------------------------------------
// Auto-range select package
// Shared types, constants and helper functions of the auto-range sequencer.
// ----------------------------------------------------------------------------
package iars_pkg;

  localparam int FRAC_BITS = 16;

  localparam int DIV_N_W     = 96;
  localparam int DIV_D_W     = 64;
  localparam int DIV_STEPS   = 96;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [11:0] CTRL_KEEP_PATH  = 12'hE1F;
  localparam logic [11:0] CTRL_KEEP_RANGE = 12'hEE3;
  localparam logic [11:0] CTRL_ADD_VX     = 12'd64;
  localparam logic [11:0] CTRL_ADD_LP     = 12'd32;
  localparam logic [11:0] CTRL_BITS_500   = 12'd0;
  localparam logic [11:0] CTRL_BITS_5K    = 12'd4;
  localparam logic [11:0] CTRL_BITS_50K   = 12'd8;

  localparam logic [15:0] RANGE_500   = 16'd500;
  localparam logic [15:0] RANGE_5K    = 16'd5000;
  localparam logic [15:0] RANGE_50K   = 16'd50000;

  localparam logic [31:0] STRAY_RESET = 32'd1000000;

  localparam logic [63:0]  ONE_SQ   = 64'd1 << (2 * FRAC_BITS);
  localparam logic [63:0]  S_BIG    = ONE_SQ * 64'd100;
  localparam logic [63:0]  S_TENTH  = ONE_SQ / 64'd100;
  localparam logic [127:0] DRIVE_THR = 128'd8100 << (4 * FRAC_BITS);

  typedef enum logic [1:0] {
    REG_FREQ_MIXED    = 2'd0,
    REG_MEASURE_TERM  = 2'd1,
    REG_STRAY_IMP     = 2'd2
  } reg_idx_e;

  typedef enum logic [1:0] {
    MT_DEVICE    = 2'd0,
    MT_REFERENCE = 2'd1,
    MT_STRAY     = 2'd2
  } meas_term_e;

  typedef enum logic [1:0] {
    PH_MEASURE = 2'd0,
    PH_BALANCE = 2'd1,
    PH_STRAY   = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    STEP_VX = 2'd0,
    STEP_LP = 2'd1,
    STEP_VR = 2'd2
  } step_e;

  typedef enum logic [5:0] {
    OP_NONE, OP_LOAD_VX, OP_LOAD_LP, OP_LOAD_VR, OP_DIFF,
    OP_EE, OP_FF, OP_XE, OP_YF, OP_YE, OP_XF, OP_WMY, OP_DERR,
    OP_DIVX, OP_SETRX, OP_DIVY, OP_SETRY,
    OP_RX2, OP_RY2, OP_RR, OP_ZZ, OP_MLO, OP_MHI, OP_WNUM, OP_DIVS, OP_SETS,
    OP_R500, OP_R5K, OP_R50K, OP_REDUCE,
    OP_VR, OP_VI, OP_WV2, OP_PLL, OP_PLH, OP_PHL, OP_PHH, OP_WHH, OP_SETV4,
    OP_EMIT
  } op_e;

  typedef enum logic [5:0] {
    ST_IDLE, ST_DIFF, ST_EE, ST_FF, ST_XE, ST_YF, ST_YE, ST_XF, ST_WMY, ST_CHK,
    ST_DIVX, ST_WX, ST_DIVY, ST_WY,
    ST_RX2, ST_RY2, ST_RR, ST_ZZ, ST_MLO, ST_MHI, ST_WNUM, ST_DIVS, ST_WS, ST_CMP,
    ST_VR, ST_VI, ST_WV2, ST_PLL, ST_PLH, ST_PHL, ST_PHH, ST_WHH, ST_V4, ST_CMP2,
    ST_EMIT
  } state_e;

  typedef struct packed {
    op_e  op;
    logic pass;
  } cmd_t;

  typedef struct packed {
    logic den_zero;
    logic div_done;
    logic s_gt_big;
    logic s_gt_one;
    logic s_gt_tenth;
    logic s_nz;
    logic acc_gt_thr;
  } sts_t;

  function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] v);
    logic signed [32:0] n;
    n = -{v[31], v};
    return (n[32] != n[31]) ? 32'sh7FFF_FFFF : n[31:0];
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat_ratio(input logic [63:0] q, input logic ovf,
                                                   input logic neg);
    logic signed [31:0] r;
    logic               big;
    big = ovf || (q[63:31] != 33'd0);
    if (neg) begin
      r = big ? 32'sh8000_0000 : -q[31:0];
    end else begin
      r = big ? 32'sh7FFF_FFFF : q[31:0];
    end
    return r;
  endfunction

endpackage

/* rtl/iars_in_if.sv */
// ----------------------------------------------------------------------------
// Phasor input channel
// Valid/ready channel carrying one detector phasor per transfer.
// ----------------------------------------------------------------------------
interface iars_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] psd_x;
  logic signed [31:0] psd_y;

  modport source (output valid, output psd_x, output psd_y, input ready);
  modport sink   (input valid, input psd_x, input psd_y, output ready);
endinterface

/* rtl/iars_out_if.sv */
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel carrying one step result per transfer.
// ----------------------------------------------------------------------------
interface iars_out_if;
  logic               valid;
  logic               ready;
  logic [11:0]        ctrl_word;
  logic [15:0]        range_ohms;
  logic signed [31:0] ratio_x;
  logic signed [31:0] ratio_y;
  logic [1:0]         next_phase;
  logic               reduce_drive;
  logic               divide_error;

  modport source (output valid, output ctrl_word, output range_ohms, output ratio_x,
                  output ratio_y, output next_phase, output reduce_drive,
                  output divide_error, input ready);
  modport sink   (input valid, input ctrl_word, input range_ohms, input ratio_x,
                  input ratio_y, input next_phase, input reduce_drive,
                  input divide_error, output ready);
endinterface

/* rtl/iars_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface iars_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/impedance_auto_range_select_top.sv */
// Vx and Lp steps: the input is loaded in the idle state and the result is registered on emit.
// Vr step: three runs of the bit-serial divider plus the multiply schedule on the single
// 33x33 multiplier, with the drive-check multiplies added when that check runs.
// Throughput: one item at a time; the next input is taken once the result is registered.
// Reset: step returns to Vx, control word 0, range 5000 ohms, registers to defaults.
// ----------------------------------------------------------------------------
// Impedance auto-range select top level
// Three-step auto-ranging sequencer with controller and datapath.
// ----------------------------------------------------------------------------
module impedance_auto_range_select_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  iars_in_if.sink    in_i,
  iars_out_if.source out_o,
  iars_cfg_if.sink   cfg_i
);

  iars_pkg::cmd_t cmd;
  iars_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  iars_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  iars_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .psd_x_i        (in_i.psd_x),
    .psd_y_i        (in_i.psd_y),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .ctrl_word_o    (out_o.ctrl_word),
    .range_ohms_o   (out_o.range_ohms),
    .ratio_x_o      (out_o.ratio_x),
    .ratio_y_o      (out_o.ratio_y),
    .next_phase_o   (out_o.next_phase),
    .reduce_drive_o (out_o.reduce_drive),
    .divide_error_o (out_o.divide_error)
  );

endmodule

/* rtl/iars_div.sv */
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division, one quotient bit per cycle, quotient saturation flag.
// ----------------------------------------------------------------------------
module iars_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [iars_pkg::DIV_N_W-1:0] num_i,
  input  logic [iars_pkg::DIV_D_W-1:0] den_i,
  output logic                         done_o,
  output logic [63:0]                  quot_o,
  output logic                         ovf_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [iars_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [iars_pkg::DIV_N_W-1:0]   n_q;
  logic [iars_pkg::DIV_D_W-1:0]   d_q;
  logic [63:0]                    r_q;
  logic [63:0]                    quot_q;
  logic                           ovf_q;
  logic [64:0]                    rem_sh;
  logic                           fits;
  logic [64:0]                    rem_nx;

  always_comb begin
    rem_sh = {r_q, n_q[iars_pkg::DIV_N_W-1]};
    fits   = rem_sh >= {1'b0, d_q};
    rem_nx = fits ? (rem_sh - {1'b0, d_q}) : rem_sh;
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == iars_pkg::DIV_CNT_W'(iars_pkg::DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= num_i;
      d_q    <= den_i;
      r_q    <= '0;
      quot_q <= '0;
      ovf_q  <= 1'b0;
    end else if (busy_q) begin
      n_q    <= {n_q[iars_pkg::DIV_N_W-2:0], 1'b0};
      r_q    <= rem_nx[63:0];
      quot_q <= {quot_q[62:0], fits};
      ovf_q  <= ovf_q | quot_q[63];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign ovf_o  = ovf_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");

endmodule

/* rtl/iars_dp.sv */
// ----------------------------------------------------------------------------
// Auto-range datapath
// Phasor store, shared multiplier, divider, range logic and result register.
// ----------------------------------------------------------------------------
module iars_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  iars_pkg::cmd_t     cmd_i,
  output iars_pkg::sts_t     sts_o,
  input  logic signed [31:0] psd_x_i,
  input  logic signed [31:0] psd_y_i,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  output logic [11:0]        ctrl_word_o,
  output logic [15:0]        range_ohms_o,
  output logic signed [31:0] ratio_x_o,
  output logic signed [31:0] ratio_y_o,
  output logic [1:0]         next_phase_o,
  output logic               reduce_drive_o,
  output logic               divide_error_o
);

  localparam int F = iars_pkg::FRAC_BITS;

  logic               freq_mixed_q;
  logic [1:0]         meas_term_q;
  logic [31:0]        stray_q;

  logic signed [31:0] vx_re_q, vx_im_q, lp_re_q, lp_im_q;
  logic [11:0]        ctrl_q;
  logic [15:0]        range_q;

  logic signed [31:0] e_q, f_q;
  logic [63:0]        den_q;
  logic signed [64:0] mx_q, my_q;
  logic signed [31:0] rx_q, ry_q;
  logic [63:0]        m_q;
  logic [31:0]        rr_q;
  logic [63:0]        zz_q;
  logic [95:0]        num_q;
  logic [63:0]        s_q;
  logic [63:0]        v2_q;
  logic [63:0]        v4_q;
  logic [127:0]       acc_q;
  logic               reduce_q, derr_q, fin_q;
  logic signed [65:0] p_q;

  logic signed [32:0] ma, mb;
  logic [63:0]        op_a, op_b;
  logic [31:0]        z_eff;
  logic signed [64:0] mx_abs, my_abs;
  logic               div_start;
  logic [95:0]        div_num;
  logic [63:0]        div_den;
  logic               div_done;
  logic [63:0]        div_quot;
  logic               div_ovf;
  logic [63:0]        add_v;
  logic [64:0]        s_sum;
  logic [1:0]         phase;

  assign z_eff  = (stray_q == 32'd0) ? 32'd1 : stray_q;
  assign op_a   = cmd_i.pass ? s_q : v2_q;
  assign op_b   = cmd_i.pass ? v4_q : v2_q;
  assign mx_abs = mx_q[64] ? -mx_q : mx_q;
  assign my_abs = my_q[64] ? -my_q : my_q;
  assign add_v  = div_ovf ? '1 : div_quot;
  assign s_sum  = {1'b0, m_q} + {1'b0, add_v};

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      iars_pkg::OP_EE:  begin ma = {e_q[31], e_q};         mb = {e_q[31], e_q};       end
      iars_pkg::OP_FF:  begin ma = {f_q[31], f_q};         mb = {f_q[31], f_q};       end
      iars_pkg::OP_XE:  begin ma = {lp_re_q[31], lp_re_q}; mb = {e_q[31], e_q};       end
      iars_pkg::OP_YF:  begin ma = {lp_im_q[31], lp_im_q}; mb = {f_q[31], f_q};       end
      iars_pkg::OP_YE:  begin ma = {lp_im_q[31], lp_im_q}; mb = {e_q[31], e_q};       end
      iars_pkg::OP_XF:  begin ma = {lp_re_q[31], lp_re_q}; mb = {f_q[31], f_q};       end
      iars_pkg::OP_RX2: begin ma = {rx_q[31], rx_q};       mb = {rx_q[31], rx_q};     end
      iars_pkg::OP_RY2: begin ma = {ry_q[31], ry_q};       mb = {ry_q[31], ry_q};     end
      iars_pkg::OP_RR:  begin ma = {17'd0, range_q};       mb = {17'd0, range_q};     end
      iars_pkg::OP_ZZ:  begin ma = {1'b0, z_eff};          mb = {1'b0, z_eff};        end
      iars_pkg::OP_MLO: begin ma = {1'b0, m_q[31:0]};      mb = {1'b0, rr_q};         end
      iars_pkg::OP_MHI: begin ma = {1'b0, m_q[63:32]};     mb = {1'b0, rr_q};         end
      iars_pkg::OP_VR:  begin ma = {vx_re_q[31], vx_re_q}; mb = {vx_re_q[31], vx_re_q}; end
      iars_pkg::OP_VI:  begin ma = {vx_im_q[31], vx_im_q}; mb = {vx_im_q[31], vx_im_q}; end
      iars_pkg::OP_PLL: begin ma = {1'b0, op_a[31:0]};     mb = {1'b0, op_b[31:0]};   end
      iars_pkg::OP_PLH: begin ma = {1'b0, op_a[31:0]};     mb = {1'b0, op_b[63:32]};  end
      iars_pkg::OP_PHL: begin ma = {1'b0, op_a[63:32]};    mb = {1'b0, op_b[31:0]};   end
      iars_pkg::OP_PHH: begin ma = {1'b0, op_a[63:32]};    mb = {1'b0, op_b[63:32]};  end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    div_start = 1'b0;
    div_num   = num_q;
    div_den   = zz_q;
    case (cmd_i.op)
      iars_pkg::OP_DIVX: begin
        div_start = 1'b1;
        div_num   = 96'(mx_abs[63:0]) << F;
        div_den   = den_q;
      end
      iars_pkg::OP_DIVY: begin
        div_start = 1'b1;
        div_num   = 96'(my_abs[63:0]) << F;
        div_den   = den_q;
      end
      iars_pkg::OP_DIVS: begin
        div_start = 1'b1;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  iars_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .ovf_o   (div_ovf)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_mixed_q <= 1'b0;
      meas_term_q  <= iars_pkg::MT_DEVICE;
      stray_q      <= iars_pkg::STRAY_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        iars_pkg::REG_FREQ_MIXED:   freq_mixed_q <= cfg_data_i[0];
        iars_pkg::REG_MEASURE_TERM: meas_term_q  <= cfg_data_i[1:0];
        iars_pkg::REG_STRAY_IMP:    stray_q      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_re_q  <= '0;
      vx_im_q  <= '0;
      lp_re_q  <= '0;
      lp_im_q  <= '0;
      ctrl_q   <= '0;
      range_q  <= iars_pkg::RANGE_5K;
      reduce_q <= 1'b0;
      derr_q   <= 1'b0;
      fin_q    <= 1'b0;
      rx_q     <= '0;
      ry_q     <= '0;
    end else begin
      case (cmd_i.op)
        iars_pkg::OP_LOAD_VX: begin
          vx_re_q  <= psd_x_i;
          vx_im_q  <= freq_mixed_q ? iars_pkg::neg_sat32(psd_y_i) : psd_y_i;
          ctrl_q   <= (ctrl_q & iars_pkg::CTRL_KEEP_PATH) + iars_pkg::CTRL_ADD_VX;
          {reduce_q, derr_q, fin_q} <= 3'b000;
          rx_q     <= '0;
          ry_q     <= '0;
        end
        iars_pkg::OP_LOAD_LP: begin
          lp_re_q  <= iars_pkg::neg_sat32(psd_x_i);
          lp_im_q  <= freq_mixed_q ? psd_y_i : iars_pkg::neg_sat32(psd_y_i);
          ctrl_q   <= (ctrl_q & iars_pkg::CTRL_KEEP_PATH) + iars_pkg::CTRL_ADD_LP;
          {reduce_q, derr_q, fin_q} <= 3'b000;
          rx_q     <= '0;
          ry_q     <= '0;
        end
        iars_pkg::OP_LOAD_VR: begin
          {reduce_q, derr_q, fin_q} <= 3'b001;
          rx_q     <= '0;
          ry_q     <= '0;
        end
        iars_pkg::OP_DERR:   derr_q   <= 1'b1;
        iars_pkg::OP_REDUCE: reduce_q <= 1'b1;
        iars_pkg::OP_SETRX:  rx_q <= iars_pkg::sat_ratio(div_quot, div_ovf, mx_q[64]);
        iars_pkg::OP_SETRY:  ry_q <= iars_pkg::sat_ratio(div_quot, div_ovf, my_q[64]);
        iars_pkg::OP_R500: begin
          range_q <= iars_pkg::RANGE_500;
          ctrl_q  <= (ctrl_q & iars_pkg::CTRL_KEEP_RANGE) + iars_pkg::CTRL_BITS_500;
        end
        iars_pkg::OP_R5K: begin
          range_q <= iars_pkg::RANGE_5K;
          ctrl_q  <= (ctrl_q & iars_pkg::CTRL_KEEP_RANGE) + iars_pkg::CTRL_BITS_5K;
        end
        iars_pkg::OP_R50K: begin
          range_q <= iars_pkg::RANGE_50K;
          ctrl_q  <= (ctrl_q & iars_pkg::CTRL_KEEP_RANGE) + iars_pkg::CTRL_BITS_50K;
        end
        default: begin
        end
      endcase
    end
  end

  // Each product is registered in p_q and taken up in the cycle after its operands were selected.
  always_ff @(posedge clk_i) begin
    p_q <= ma * mb;
    case (cmd_i.op)
      iars_pkg::OP_DIFF: begin
        e_q <= iars_pkg::sat33(33'(vx_re_q) - 33'(lp_re_q));
        f_q <= iars_pkg::sat33(33'(vx_im_q) - 33'(lp_im_q));
      end
      iars_pkg::OP_FF:   den_q <= p_q[63:0];
      iars_pkg::OP_XE:   den_q <= den_q + p_q[63:0];
      iars_pkg::OP_YF:   mx_q  <= p_q[64:0];
      iars_pkg::OP_YE:   mx_q  <= mx_q + p_q[64:0];
      iars_pkg::OP_XF:   my_q  <= p_q[64:0];
      iars_pkg::OP_WMY:  my_q  <= my_q - p_q[64:0];
      iars_pkg::OP_RY2:  m_q   <= p_q[63:0];
      iars_pkg::OP_RR:   m_q   <= m_q + p_q[63:0];
      iars_pkg::OP_ZZ:   rr_q  <= p_q[31:0];
      iars_pkg::OP_MLO:  zz_q  <= p_q[63:0];
      iars_pkg::OP_MHI:  num_q <= {32'd0, p_q[63:0]};
      iars_pkg::OP_WNUM: num_q <= num_q + {p_q[63:0], 32'd0};
      iars_pkg::OP_SETS: s_q   <= s_sum[64] ? '1 : s_sum[63:0];
      iars_pkg::OP_VI:   v2_q  <= p_q[63:0];
      iars_pkg::OP_WV2:  v2_q  <= v2_q + p_q[63:0];
      iars_pkg::OP_PLH:  acc_q <= {64'd0, p_q[63:0]};
      iars_pkg::OP_PHL:  acc_q <= acc_q + {32'd0, p_q[63:0], 32'd0};
      iars_pkg::OP_PHH:  acc_q <= acc_q + {32'd0, p_q[63:0], 32'd0};
      iars_pkg::OP_WHH:  acc_q <= acc_q + {p_q[63:0], 64'd0};
      iars_pkg::OP_SETV4: begin
        v4_q <= (acc_q[127:2*F+64] != '0) ? '1 : acc_q[2*F+63:2*F];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (!fin_q) begin
      phase = iars_pkg::PH_MEASURE;
    end else if (meas_term_q == iars_pkg::MT_STRAY) begin
      phase = iars_pkg::PH_STRAY;
    end else begin
      phase = iars_pkg::PH_BALANCE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == iars_pkg::OP_EMIT) begin
      ctrl_word_o    <= ctrl_q;
      range_ohms_o   <= range_q;
      ratio_x_o      <= rx_q;
      ratio_y_o      <= ry_q;
      next_phase_o   <= phase;
      reduce_drive_o <= reduce_q;
      divide_error_o <= derr_q;
    end
  end

  assign sts_o.den_zero   = (den_q == '0);
  assign sts_o.div_done   = div_done;
  assign sts_o.s_gt_big   = (s_q > iars_pkg::S_BIG);
  assign sts_o.s_gt_one   = (s_q > iars_pkg::ONE_SQ);
  assign sts_o.s_gt_tenth = (s_q > iars_pkg::S_TENTH);
  assign sts_o.s_nz       = (s_q != '0);
  assign sts_o.acc_gt_thr = (acc_q > iars_pkg::DRIVE_THR);

endmodule

/* rtl/iars_ctrl.sv */
// ----------------------------------------------------------------------------
// Auto-range controller
// Step sequencer and operation scheduler driving the datapath.
// ----------------------------------------------------------------------------
module iars_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output iars_pkg::cmd_t cmd_o,
  input  iars_pkg::sts_t sts_i
);

  iars_pkg::state_e state_q, state_d;
  iars_pkg::step_e  step_q, step_d;
  logic             pass_q, pass_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iars_pkg::ST_IDLE;
      step_q      <= iars_pkg::STEP_VX;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    pass_d      = pass_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o.op    = iars_pkg::OP_NONE;
    cmd_o.pass  = pass_q;
    case (state_q)
      iars_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (step_q)
            iars_pkg::STEP_VX: begin
              cmd_o.op = iars_pkg::OP_LOAD_VX;
              step_d   = iars_pkg::STEP_LP;
              state_d  = iars_pkg::ST_EMIT;
            end
            iars_pkg::STEP_LP: begin
              cmd_o.op = iars_pkg::OP_LOAD_LP;
              step_d   = iars_pkg::STEP_VR;
              state_d  = iars_pkg::ST_EMIT;
            end
            default: begin
              cmd_o.op = iars_pkg::OP_LOAD_VR;
              step_d   = iars_pkg::STEP_VX;
              state_d  = iars_pkg::ST_DIFF;
            end
          endcase
        end
      end
      iars_pkg::ST_DIFF: begin cmd_o.op = iars_pkg::OP_DIFF; state_d = iars_pkg::ST_EE; end
      iars_pkg::ST_EE:   begin cmd_o.op = iars_pkg::OP_EE;   state_d = iars_pkg::ST_FF; end
      iars_pkg::ST_FF:   begin cmd_o.op = iars_pkg::OP_FF;   state_d = iars_pkg::ST_XE; end
      iars_pkg::ST_XE:   begin cmd_o.op = iars_pkg::OP_XE;   state_d = iars_pkg::ST_YF; end
      iars_pkg::ST_YF:   begin cmd_o.op = iars_pkg::OP_YF;   state_d = iars_pkg::ST_YE; end
      iars_pkg::ST_YE:   begin cmd_o.op = iars_pkg::OP_YE;   state_d = iars_pkg::ST_XF; end
      iars_pkg::ST_XF:   begin cmd_o.op = iars_pkg::OP_XF;   state_d = iars_pkg::ST_WMY; end
      iars_pkg::ST_WMY:  begin cmd_o.op = iars_pkg::OP_WMY;  state_d = iars_pkg::ST_CHK; end
      iars_pkg::ST_CHK: begin
        if (sts_i.den_zero) begin
          cmd_o.op = iars_pkg::OP_DERR;
          state_d  = iars_pkg::ST_EMIT;
        end else begin
          state_d  = iars_pkg::ST_DIVX;
        end
      end
      iars_pkg::ST_DIVX: begin cmd_o.op = iars_pkg::OP_DIVX; state_d = iars_pkg::ST_WX; end
      iars_pkg::ST_WX: begin
        if (sts_i.div_done) begin
          cmd_o.op = iars_pkg::OP_SETRX;
          state_d  = iars_pkg::ST_DIVY;
        end
      end
      iars_pkg::ST_DIVY: begin cmd_o.op = iars_pkg::OP_DIVY; state_d = iars_pkg::ST_WY; end
      iars_pkg::ST_WY: begin
        if (sts_i.div_done) begin
          cmd_o.op = iars_pkg::OP_SETRY;
          state_d  = iars_pkg::ST_RX2;
        end
      end
      iars_pkg::ST_RX2:  begin cmd_o.op = iars_pkg::OP_RX2;  state_d = iars_pkg::ST_RY2; end
      iars_pkg::ST_RY2:  begin cmd_o.op = iars_pkg::OP_RY2;  state_d = iars_pkg::ST_RR; end
      iars_pkg::ST_RR:   begin cmd_o.op = iars_pkg::OP_RR;   state_d = iars_pkg::ST_ZZ; end
      iars_pkg::ST_ZZ:   begin cmd_o.op = iars_pkg::OP_ZZ;   state_d = iars_pkg::ST_MLO; end
      iars_pkg::ST_MLO:  begin cmd_o.op = iars_pkg::OP_MLO;  state_d = iars_pkg::ST_MHI; end
      iars_pkg::ST_MHI:  begin cmd_o.op = iars_pkg::OP_MHI;  state_d = iars_pkg::ST_WNUM; end
      iars_pkg::ST_WNUM: begin cmd_o.op = iars_pkg::OP_WNUM; state_d = iars_pkg::ST_DIVS; end
      iars_pkg::ST_DIVS: begin cmd_o.op = iars_pkg::OP_DIVS; state_d = iars_pkg::ST_WS; end
      iars_pkg::ST_WS: begin
        if (sts_i.div_done) begin
          cmd_o.op = iars_pkg::OP_SETS;
          state_d  = iars_pkg::ST_CMP;
        end
      end
      iars_pkg::ST_CMP: begin
        state_d = iars_pkg::ST_EMIT;
        if (sts_i.s_gt_big) begin
          pass_d  = 1'b0;
          state_d = iars_pkg::ST_VR;
        end else if (sts_i.s_gt_one) begin
          cmd_o.op = iars_pkg::OP_R500;
        end else if (sts_i.s_gt_tenth) begin
          cmd_o.op = iars_pkg::OP_R5K;
        end else if (sts_i.s_nz) begin
          cmd_o.op = iars_pkg::OP_R50K;
        end
      end
      iars_pkg::ST_VR:   begin cmd_o.op = iars_pkg::OP_VR;   state_d = iars_pkg::ST_VI; end
      iars_pkg::ST_VI:   begin cmd_o.op = iars_pkg::OP_VI;   state_d = iars_pkg::ST_WV2; end
      iars_pkg::ST_WV2:  begin cmd_o.op = iars_pkg::OP_WV2;  state_d = iars_pkg::ST_PLL; end
      iars_pkg::ST_PLL:  begin cmd_o.op = iars_pkg::OP_PLL;  state_d = iars_pkg::ST_PLH; end
      iars_pkg::ST_PLH:  begin cmd_o.op = iars_pkg::OP_PLH;  state_d = iars_pkg::ST_PHL; end
      iars_pkg::ST_PHL:  begin cmd_o.op = iars_pkg::OP_PHL;  state_d = iars_pkg::ST_PHH; end
      iars_pkg::ST_PHH:  begin cmd_o.op = iars_pkg::OP_PHH;  state_d = iars_pkg::ST_WHH; end
      iars_pkg::ST_WHH: begin
        cmd_o.op = iars_pkg::OP_WHH;
        state_d  = pass_q ? iars_pkg::ST_CMP2 : iars_pkg::ST_V4;
      end
      iars_pkg::ST_V4: begin
        cmd_o.op = iars_pkg::OP_SETV4;
        pass_d   = 1'b1;
        state_d  = iars_pkg::ST_PLL;
      end
      iars_pkg::ST_CMP2: begin
        cmd_o.op = sts_i.acc_gt_thr ? iars_pkg::OP_REDUCE : iars_pkg::OP_R500;
        state_d  = iars_pkg::ST_EMIT;
      end
      iars_pkg::ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = iars_pkg::OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = iars_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = iars_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != iars_pkg::ST_IDLE))
    else $error("accepted item did not start work");

  a_emit_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iars_pkg::ST_EMIT && out_valid_q && !out_ready_i)
      |=> (state_q == iars_pkg::ST_EMIT))
    else $error("result emitted over an untaken result");

  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == iars_pkg::OP_EMIT) |=> out_valid_q)
    else $error("emitted result not shown as valid");

endmodule
